[design/gbe_pkg.sv]
package gbe_pkg;

	localparam int CAPACITY = 4096;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int GAP_W    = ADDR_W + 1;

	localparam int ACTION_W = 3;
	localparam int CHAR_W   = 8;
	localparam int POS_W    = 13;
	localparam int CNT_W    = 13;

	// common width for comparing a request position against gap counts
	localparam int CMP_W = (GAP_W > POS_W) ? GAP_W : POS_W;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT     = 3'd0,
		ACT_DEL_BEFORE = 3'd1,
		ACT_DEL_AFTER  = 3'd2,
		ACT_MOVE       = 3'd3,
		ACT_READ       = 3'd4
	} gbe_action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RD_WAIT,
		ST_MOVE,
		ST_FIN
	} gbe_state_t;

endpackage

[design/gbe_req_if.sv]
interface gbe_req_if;
	logic                        valid;
	logic                        ready;
	logic [gbe_pkg::ACTION_W-1:0] action;
	logic [gbe_pkg::CHAR_W-1:0]   char_in;
	logic [gbe_pkg::POS_W-1:0]    position;

	modport source(output valid, action, char_in, position, input ready);
	modport sink(input valid, action, char_in, position, output ready);
endinterface

[design/gbe_rsp_if.sv]
interface gbe_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [gbe_pkg::CHAR_W-1:0] char_out;
	logic                      status;
	logic [gbe_pkg::CNT_W-1:0]  cursor;
	logic [gbe_pkg::CNT_W-1:0]  text_length;

	modport source(output valid, char_out, status, cursor, text_length, input ready);
	modport sink(input valid, char_out, status, cursor, text_length, output ready);
endinterface

[design/gap_buffer_edit_engine.sv]
// Gap-buffer text store of CAPACITY bytes held in one synchronous RAM (one write port,
// one read port, registered read data). Each request is one action: insert at the
// cursor, delete before or after it, move it, or read a byte at a logical position,
// and each yields exactly one response carrying the post-action cursor and text
// length. Requests are taken one at a time: insert, both deletes, unused action codes,
// an out-of-range read and a move to the current cursor finish in ST_EXEC, an in-range
// read adds ST_RD_WAIT for the registered RAM data, and a cursor move passes through
// ST_MOVE and ST_FIN, the RAM shifting one byte per cycle across the gap through
// its read and write ports. A response waits in an output register; the next request
// is accepted while it is still pending, and a finished action stalls only when that
// register is still occupied. The RAM needs no clearing after reset: only inserted
// bytes ever become text.
module gap_buffer_edit_engine (
	input  logic           clk,
	input  logic           arst_n,
	gbe_req_if.sink        req,
	gbe_rsp_if.source      rsp
);
	import gbe_pkg::*;

	// text RAM
	logic [CHAR_W-1:0] text_store [CAPACITY];
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CHAR_W-1:0] mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [CHAR_W-1:0] mem_rdata_q;

	// control
	gbe_state_t state_q, state_d;
	logic [GAP_W-1:0] gap_first_q, gap_first_d;
	logic [GAP_W-1:0] gap_limit_q, gap_limit_d;

	// latched request
	logic [ACTION_W-1:0] cmd_action_q;
	logic [CHAR_W-1:0]   cmd_char_q;
	logic [POS_W-1:0]    cmd_pos_q;

	// move sequencer
	logic [ADDR_W-1:0] rd_ptr_q, rd_ptr_d;
	logic [ADDR_W-1:0] wr_ptr_q, wr_ptr_d;
	logic [GAP_W-1:0]  rd_left_q, rd_left_d;
	logic [GAP_W-1:0]  wr_left_q, wr_left_d;
	logic [GAP_W-1:0]  delta_q, delta_d;
	logic [GAP_W-1:0]  tgt_q, tgt_d;
	logic              dir_left_q, dir_left_d;
	logic              pend_s1;
	logic              move_rd;

	// output register
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_status_q;
	logic [CNT_W-1:0]  out_cursor_q;
	logic [CNT_W-1:0]  out_len_q;
	logic              out_load;
	logic [CHAR_W-1:0] res_char;
	logic              res_status;
	logic              slot_free;

	// helpers
	logic [GAP_W-1:0] fill_len;
	logic [GAP_W-1:0] len_d;
	logic [GAP_W-1:0] gf_m1;
	logic [GAP_W-1:0] gl_m1;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] len_ext;
	logic [CMP_W-1:0] gf_ext;
	logic [CMP_W-1:0] clamp_pos;
	logic [CMP_W-1:0] phys_ext;
	logic [GAP_W-1:0] move_tgt;

	assign fill_len  = GAP_W'(CAPACITY) - (gap_limit_q - gap_first_q);
	assign len_d     = GAP_W'(CAPACITY) - (gap_limit_d - gap_first_d);
	assign gf_m1     = gap_first_q - GAP_W'(1);
	assign gl_m1     = gap_limit_q - GAP_W'(1);
	assign pos_ext   = CMP_W'(cmd_pos_q);
	assign len_ext   = CMP_W'(fill_len);
	assign gf_ext    = CMP_W'(gap_first_q);
	assign clamp_pos = (pos_ext > len_ext) ? len_ext : pos_ext;
	assign move_tgt  = GAP_W'(clamp_pos);
	// logical to physical: skip over the gap once past the cursor
	assign phys_ext  = (pos_ext < gf_ext) ? pos_ext
	                                      : CMP_W'(gap_limit_q) + (pos_ext - gf_ext);

	assign slot_free = !out_valid_q || rsp.ready;

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.char_out    = out_char_q;
	assign rsp.status      = out_status_q;
	assign rsp.cursor      = out_cursor_q;
	assign rsp.text_length = out_len_q;

	always_comb begin
		state_d     = state_q;
		gap_first_d = gap_first_q;
		gap_limit_d = gap_limit_q;
		rd_ptr_d    = rd_ptr_q;
		wr_ptr_d    = wr_ptr_q;
		rd_left_d   = rd_left_q;
		wr_left_d   = wr_left_q;
		delta_d     = delta_q;
		tgt_d       = tgt_q;
		dir_left_d  = dir_left_q;
		move_rd     = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = gap_first_q[ADDR_W-1:0];
		mem_wdata   = cmd_char_q;
		mem_re      = 1'b0;
		mem_raddr   = phys_ext[ADDR_W-1:0];
		out_load    = 1'b0;
		res_char    = '0;
		res_status  = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (cmd_action_q)
					ACT_INSERT: begin
						// commit only once the response has somewhere to go
						if (slot_free) begin
							out_load = 1'b1;
							state_d  = ST_IDLE;
							if (gap_first_q >= gap_limit_q) begin
								res_status = 1'b1;
							end else begin
								mem_we      = 1'b1;
								gap_first_d = gap_first_q + GAP_W'(1);
							end
						end
					end
					ACT_DEL_BEFORE: begin
						if (slot_free) begin
							out_load = 1'b1;
							state_d  = ST_IDLE;
							if (gap_first_q == '0) begin
								res_status = 1'b1;
							end else begin
								gap_first_d = gf_m1;
							end
						end
					end
					ACT_DEL_AFTER: begin
						if (slot_free) begin
							out_load = 1'b1;
							state_d  = ST_IDLE;
							if (gap_limit_q >= GAP_W'(CAPACITY)) begin
								res_status = 1'b1;
							end else begin
								gap_limit_d = gap_limit_q + GAP_W'(1);
							end
						end
					end
					ACT_MOVE: begin
						if (move_tgt == gap_first_q) begin
							if (slot_free) begin
								out_load = 1'b1;
								state_d  = ST_IDLE;
							end
						end else begin
							// set up the byte shuttle across the gap
							tgt_d   = move_tgt;
							state_d = ST_MOVE;
							if (move_tgt < gap_first_q) begin
								dir_left_d = 1'b1;
								delta_d    = gap_first_q - move_tgt;
								rd_ptr_d   = gf_m1[ADDR_W-1:0];
								wr_ptr_d   = gl_m1[ADDR_W-1:0];
								rd_left_d  = gap_first_q - move_tgt;
								wr_left_d  = gap_first_q - move_tgt;
							end else begin
								dir_left_d = 1'b0;
								delta_d    = move_tgt - gap_first_q;
								rd_ptr_d   = gap_limit_q[ADDR_W-1:0];
								wr_ptr_d   = gap_first_q[ADDR_W-1:0];
								rd_left_d  = move_tgt - gap_first_q;
								wr_left_d  = move_tgt - gap_first_q;
							end
						end
					end
					ACT_READ: begin
						if (pos_ext >= len_ext) begin
							if (slot_free) begin
								out_load = 1'b1;
								state_d  = ST_IDLE;
							end
						end else begin
							mem_re  = 1'b1;
							state_d = ST_RD_WAIT;
						end
					end
					default: begin
						if (slot_free) begin
							out_load = 1'b1;
							state_d  = ST_IDLE;
						end
					end
				endcase
			end
			ST_RD_WAIT: begin
				// read data holds in the RAM output register until taken
				if (slot_free) begin
					out_load = 1'b1;
					res_char = mem_rdata_q;
					state_d  = ST_IDLE;
				end
			end
			ST_MOVE: begin
				// read one byte a cycle, write it back in the following cycle
				move_rd   = (rd_left_q != '0);
				mem_re    = move_rd;
				mem_raddr = rd_ptr_q;
				if (move_rd) begin
					rd_ptr_d  = dir_left_q ? rd_ptr_q - ADDR_W'(1) : rd_ptr_q + ADDR_W'(1);
					rd_left_d = rd_left_q - GAP_W'(1);
				end
				mem_we    = pend_s1;
				mem_waddr = wr_ptr_q;
				mem_wdata = mem_rdata_q;
				if (pend_s1) begin
					wr_ptr_d  = dir_left_q ? wr_ptr_q - ADDR_W'(1) : wr_ptr_q + ADDR_W'(1);
					wr_left_d = wr_left_q - GAP_W'(1);
					if (wr_left_q == GAP_W'(1)) begin
						gap_first_d = tgt_q;
						gap_limit_d = dir_left_q ? gap_limit_q - delta_q
						                         : gap_limit_q + delta_q;
						state_d     = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			text_store[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= text_store[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gap_first_q <= '0;
			gap_limit_q <= GAP_W'(CAPACITY);
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			rd_left_q   <= '0;
			wr_left_q   <= '0;
		end else begin
			state_q     <= state_d;
			gap_first_q <= gap_first_d;
			gap_limit_q <= gap_limit_d;
			pend_s1     <= move_rd;
			rd_left_q   <= rd_left_d;
			wr_left_q   <= wr_left_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_action_q <= req.action;
			cmd_char_q   <= req.char_in;
			cmd_pos_q    <= req.position;
		end
		rd_ptr_q   <= rd_ptr_d;
		wr_ptr_q   <= wr_ptr_d;
		delta_q    <= delta_d;
		tgt_q      <= tgt_d;
		dir_left_q <= dir_left_d;
		if (out_load) begin
			out_char_q   <= res_char;
			out_status_q <= res_status;
			out_cursor_q <= CNT_W'(gap_first_d);
			out_len_q    <= CNT_W'(len_d);
		end
	end

	// the gap never inverts or runs past the end of the RAM
	a_gap_order: assert property (@(posedge clk) disable iff (!arst_n)
		(gap_first_q <= gap_limit_q) && (gap_limit_q <= GAP_W'(CAPACITY)))
		else $error("gap bounds broken");

	// an idle cycle leaves the cursor and gap untouched
	a_idle_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> ($stable(gap_first_q) && $stable(gap_limit_q)))
		else $error("gap changed while idle");

	// the byte shuttle never reads the entry it writes in the same cycle
	a_move_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOVE && mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("move read and write collide");

	// a response is loaded only when the output register is free or draining
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || rsp.ready))
		else $error("pending response overwritten");

endmodule

[tb/gap_buffer_edit_engine_test.sv]
`timescale 1ns / 100ps

module gap_buffer_edit_engine_test;
	import gbe_pkg::*;

	// action codes the block does not define; they must leave the text alone
	localparam logic [ACTION_W-1:0] ACT_SPARE_LO  = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_SPARE_MID = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE_HI  = 3'd7;

	localparam int RANDOM_PER_PHASE = 462;
	localparam int HOLD_CYCLES      = 400;
	localparam int DRAIN_CYCLES     = 20;
	localparam int CYCLE_LIMIT      = 3_000_000;
	localparam int REPORT_MAX       = 10;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [CHAR_W-1:0]   char_in;
		logic [POS_W-1:0]    position;
	} edit_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_out;
		logic              status;
		logic [CNT_W-1:0]  cursor;
		logic [CNT_W-1:0]  text_length;
	} reply_t;

	logic clk;
	logic arst_n;

	gbe_req_if req_ch();
	gbe_rsp_if rsp_ch();

	gap_buffer_edit_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// Shadow copy of the gap buffer: bytes before gap_first plus bytes from
	// gap_limit to the top of the store form the text.
	bit [CHAR_W-1:0] shadow_text [CAPACITY];
	int              gap_first = 0;
	int              gap_limit = CAPACITY;

	edit_t  edits_to_send [$];
	reply_t replies_due [$];

	int  mismatches      = 0;
	int  cycle_count     = 0;
	int  sender_idle_pct = 21;
	int  reply_idle_pct  = 61;
	int  hold_tickets    = 0;
	int  hold_served     = 0;
	int  hold_left       = 0;
	bit  req_fired       = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int used_len();
		return CAPACITY - (gap_limit - gap_first);
	endfunction

	// Apply one edit to the shadow buffer and return the reply it must produce.
	function automatic reply_t perform_edit(edit_t e);
		reply_t r;
		int     target;
		int     phys;
		r = '0;
		case (e.action)
			ACT_INSERT: begin
				// an empty gap means a full buffer: reject, change nothing
				if (gap_first >= gap_limit) begin
					r.status = 1'b1;
				end else begin
					shadow_text[gap_first] = e.char_in;
					gap_first++;
				end
			end
			ACT_DEL_BEFORE: begin
				if (gap_first == 0) begin
					r.status = 1'b1;
				end else begin
					gap_first--;
				end
			end
			ACT_DEL_AFTER: begin
				if (gap_limit >= CAPACITY) begin
					r.status = 1'b1;
				end else begin
					gap_limit++;
				end
			end
			ACT_MOVE: begin
				// clamp to the text, then carry bytes across the gap one at a time
				target = int'(e.position);
				if (target > used_len()) begin
					target = used_len();
				end
				while (gap_first > target) begin
					gap_first--;
					gap_limit--;
					shadow_text[gap_limit] = shadow_text[gap_first];
				end
				while (gap_first < target) begin
					shadow_text[gap_first] = shadow_text[gap_limit];
					gap_first++;
					gap_limit++;
				end
			end
			ACT_READ: begin
				// out-of-range reads return zero with status done
				if (int'(e.position) < used_len()) begin
					if (int'(e.position) < gap_first) begin
						phys = int'(e.position);
					end else begin
						phys = gap_limit + (int'(e.position) - gap_first);
					end
					if (phys < CAPACITY) begin
						r.char_out = shadow_text[phys];
					end
				end
			end
			default: begin
			end
		endcase
		r.cursor      = gap_first[CNT_W-1:0];
		r.text_length = CNT_W'(used_len());
		return r;
	endfunction

	task automatic push_edit(logic [ACTION_W-1:0] act, logic [CHAR_W-1:0] ch,
			logic [POS_W-1:0] pos);
		edit_t e;
		e.action   = act;
		e.char_in  = ch;
		e.position = pos;
		edits_to_send.push_back(e);
	endtask

	task automatic wait_backlog_empty();
		while (edits_to_send.size() != 0) @(posedge clk);
	endtask

	// Well-formed edit traffic with random content. The text length drifts
	// toward a goal that is usually small, so cursor moves stay short; now and
	// then a far position exercises clamping and out-of-range reads.
	task automatic queue_random_edits(int count);
		int    made;
		int    len_now;
		int    goal;
		int    roll;
		int    ins_cut;
		int    b;
		edit_t e;
		made = 0;
		while (made < count) begin
			wait_backlog_empty();
			len_now = used_len();
			goal = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 400) :
				$urandom_range(0, 48);
			for (b = 0; b < 16 && made < count; b++) begin
				roll       = $urandom_range(0, 99);
				ins_cut    = (len_now < goal) ? 45 : 15;
				e.char_in  = CHAR_W'($urandom_range(0, 255));
				e.position = ($urandom_range(0, 7) == 0) ?
					POS_W'($urandom_range(0, CAPACITY)) :
					POS_W'($urandom_range(0, len_now + 1));
				if (roll < ins_cut) begin
					e.action = ACT_INSERT;
					if (len_now < CAPACITY) len_now++;
				end else if (roll < ins_cut + 12) begin
					e.action = ACT_DEL_BEFORE;
					if (len_now > 0) len_now--;
				end else if (roll < ins_cut + 24) begin
					e.action = ACT_DEL_AFTER;
					if (len_now > 0) len_now--;
				end else if (roll < ins_cut + 38) begin
					e.action = ACT_MOVE;
				end else if (roll < 97) begin
					e.action = ACT_READ;
				end else begin
					e.action = ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
				end
				edits_to_send.push_back(e);
				made++;
			end
		end
	endtask

	// Main sequence: reset, directed corners, three phases of random traffic
	// with varied idling and stalls, then drain and judge.
	initial begin
		int k;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty text: reads, deletes and moves all hit the edges
		push_edit(ACT_READ, '0, 0);
		push_edit(ACT_DEL_BEFORE, '0, '0);
		push_edit(ACT_DEL_AFTER, '0, '0);
		push_edit(ACT_MOVE, '0, POS_W'(CAPACITY));
		push_edit(ACT_INSERT, 8'h00, '0);
		push_edit(ACT_INSERT, 8'hFF, '0);
		push_edit(ACT_INSERT, 8'hA5, '0);
		push_edit(ACT_READ, '0, 0);
		push_edit(ACT_READ, '0, 1);
		push_edit(ACT_READ, '0, 2);
		push_edit(ACT_READ, '0, 3);
		push_edit(ACT_READ, '0, POS_W'(CAPACITY));
		push_edit(ACT_MOVE, '0, 1);
		push_edit(ACT_INSERT, 8'h5A, '0);
		push_edit(ACT_MOVE, '0, 0);
		push_edit(ACT_READ, '0, 1);
		push_edit(ACT_DEL_AFTER, '0, '0);
		push_edit(ACT_MOVE, '0, POS_W'(CAPACITY));
		push_edit(ACT_DEL_AFTER, '0, '0);
		push_edit(ACT_MOVE, '0, 3);
		push_edit(ACT_DEL_BEFORE, '0, '0);
		push_edit(ACT_SPARE_LO, 8'hFF, 13'h1FFF);
		push_edit(ACT_SPARE_MID, 8'h55, 13'h0AAA);
		push_edit(ACT_SPARE_HI, 8'hAA, 13'h1555);
		push_edit(ACT_READ, '0, 2);

		// sender idles 21%, receiver 61%; stall the reply side for a long
		// stretch while a burst of requests keeps coming
		wait_backlog_empty();
		for (k = 0; k < 40; k++) begin
			push_edit((k % 3 == 0) ? ACT_READ : ACT_INSERT,
				CHAR_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 40)));
		end
		hold_tickets++;
		queue_random_edits(RANDOM_PER_PHASE);

		wait_backlog_empty();
		sender_idle_pct = 61;
		reply_idle_pct  = 21;
		queue_random_edits(RANDOM_PER_PHASE);

		wait_backlog_empty();
		sender_idle_pct = 0;
		reply_idle_pct  = 0;
		hold_tickets++;
		queue_random_edits(RANDOM_PER_PHASE);

		wait_backlog_empty();
		while (replies_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && replies_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Long reply-side stall, counted here; each ticket buys one stretch.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
		end else if (hold_served != hold_tickets) begin
			hold_left = HOLD_CYCLES;
			hold_served++;
		end
	end

	// Request driver: hold an offered request until it is taken, otherwise
	// offer the next pending one or idle at random.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid    <= 1'b0;
			req_ch.action   <= '0;
			req_ch.char_in  <= '0;
			req_ch.position <= '0;
		end else if (req_ch.valid && !req_fired) begin
			// hold the current request
		end else if (edits_to_send.size() != 0 &&
				$urandom_range(0, 99) >= sender_idle_pct) begin
			req_ch.action   <= edits_to_send[0].action;
			req_ch.char_in  <= edits_to_send[0].char_in;
			req_ch.position <= edits_to_send[0].position;
			req_ch.valid    <= 1'b1;
		end else begin
			req_ch.valid <= 1'b0;
		end
	end

	// Reply receiver: drop ready during a hold, otherwise stall at random.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= reply_idle_pct);
		end
	end

	// Monitor: predict on each accepted request, then check each accepted reply
	// against the oldest prediction.
	always @(posedge clk) begin
		edit_t  taken;
		reply_t want;
		reply_t got;
		req_fired = req_ch.valid && req_ch.ready;
		if (arst_n) begin
			if (req_fired) begin
				taken = edits_to_send.pop_front();
				replies_due.push_back(perform_edit(taken));
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.char_out    = rsp_ch.char_out;
				got.status      = rsp_ch.status;
				got.cursor      = rsp_ch.cursor;
				got.text_length = rsp_ch.text_length;
				if (replies_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("unexpected reply: char=%h st=%b cur=%0d len=%0d",
							got.char_out, got.status, got.cursor, got.text_length);
					end
				end else begin
					want = replies_due.pop_front();
					if (got.char_out !== want.char_out || got.status !== want.status ||
							got.cursor !== want.cursor ||
							got.text_length !== want.text_length) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$display("reply mismatch: exp char=%h st=%b cur=%0d len=%0d, %s",
								want.char_out, want.status, want.cursor, want.text_length,
								$sformatf("got char=%h st=%b cur=%0d len=%0d",
									got.char_out, got.status, got.cursor,
									got.text_length));
						end
					end
				end
			end
		end
	end

endmodule
